// ===== rtl/core/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

    // Operation codes carried on the slave-side tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Step kinds of a transaction program
    localparam logic [2:0] K_END   = 3'd0;
    localparam logic [2:0] K_FIX   = 3'd1;
    localparam logic [2:0] K_SEND  = 3'd2;
    localparam logic [2:0] K_ACK   = 3'd3;
    localparam logic [2:0] K_RECV  = 3'd4;
    localparam logic [2:0] K_MNACK = 3'd5;

    // Byte sources for a send step
    localparam logic [2:0] SRC_ADDR_WR = 3'd0;
    localparam logic [2:0] SRC_ADDR_RD = 3'd1;
    localparam logic [2:0] SRC_CTRL    = 3'd2;
    localparam logic [2:0] SRC_DAC_CMD = 3'd3;
    localparam logic [2:0] SRC_VALUE   = 3'd4;

    localparam logic [7:0] DAC_CMD_BYTE = 8'h40;

    localparam int PHASE_W = 6;
    localparam int BIT_W   = 4;

    // Fixed line levels for a fixed step: {scl, sda}
    localparam logic [2:0] FIX_LL = 3'd0;
    localparam logic [2:0] FIX_LH = 3'd1;
    localparam logic [2:0] FIX_HL = 3'd2;
    localparam logic [2:0] FIX_HH = 3'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] arg;
    } t_entry;

    typedef struct packed {
        logic [7:0] hold_ticks;
        logic [6:0] dev_addr;
    } t_cfg;

    typedef struct packed {
        logic       nack_seen;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_level;
        logic       scl_level;
    } t_result;

    // Transaction programs, indexed by phase (1 = first step)
    function automatic t_entry prog_entry(input logic is_read, input logic [PHASE_W-1:0] phase);
        t_entry e;
        e = '{kind: K_END, arg: 3'd0};
        if (is_read) begin
            unique case (phase)
                6'd1:    e = '{kind: K_FIX,   arg: FIX_HH};
                6'd2:    e = '{kind: K_FIX,   arg: FIX_HL};
                6'd3:    e = '{kind: K_SEND,  arg: SRC_ADDR_WR};
                6'd4:    e = '{kind: K_ACK,   arg: 3'd0};
                6'd5:    e = '{kind: K_SEND,  arg: SRC_CTRL};
                6'd6:    e = '{kind: K_ACK,   arg: 3'd0};
                6'd7:    e = '{kind: K_FIX,   arg: FIX_LH};
                6'd8:    e = '{kind: K_FIX,   arg: FIX_HH};
                6'd9:    e = '{kind: K_FIX,   arg: FIX_HL};
                6'd10:   e = '{kind: K_SEND,  arg: SRC_ADDR_RD};
                6'd11:   e = '{kind: K_ACK,   arg: 3'd0};
                6'd12:   e = '{kind: K_RECV,  arg: 3'd0};
                6'd13:   e = '{kind: K_MNACK, arg: 3'd0};
                6'd14:   e = '{kind: K_FIX,   arg: FIX_LL};
                6'd15:   e = '{kind: K_FIX,   arg: FIX_HL};
                6'd16:   e = '{kind: K_FIX,   arg: FIX_HH};
                default: e = '{kind: K_END,   arg: 3'd0};
            endcase
        end else begin
            unique case (phase)
                6'd1:    e = '{kind: K_FIX,   arg: FIX_HH};
                6'd2:    e = '{kind: K_FIX,   arg: FIX_HL};
                6'd3:    e = '{kind: K_SEND,  arg: SRC_ADDR_WR};
                6'd4:    e = '{kind: K_ACK,   arg: 3'd0};
                6'd5:    e = '{kind: K_SEND,  arg: SRC_DAC_CMD};
                6'd6:    e = '{kind: K_ACK,   arg: 3'd0};
                6'd7:    e = '{kind: K_SEND,  arg: SRC_VALUE};
                6'd8:    e = '{kind: K_ACK,   arg: 3'd0};
                6'd9:    e = '{kind: K_FIX,   arg: FIX_LL};
                6'd10:   e = '{kind: K_FIX,   arg: FIX_HL};
                6'd11:   e = '{kind: K_FIX,   arg: FIX_HH};
                default: e = '{kind: K_END,   arg: 3'd0};
            endcase
        end
        return e;
    endfunction

    // Number of half-bit segments in a step
    function automatic logic [BIT_W:0] unit_length(input logic [2:0] kind);
        logic [BIT_W:0] len;
        case (kind) inside
            K_FIX:          len = 5'd1;
            K_SEND, K_RECV: len = 5'd16;
            default:        len = 5'd2;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/i2cm_seq.sv =====
`timescale 1ns / 1ps

module i2cm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  i2cm_pkg::t_cfg    i_cfg,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_ctrl,
    input  logic [7:0]        i_value,
    input  logic              i_sda,
    output i2cm_pkg::t_result o_res
);

    logic [i2cm_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [i2cm_pkg::BIT_W-1:0]   r_bit, n_bit;
    logic [7:0]                   r_shift, n_shift;
    logic [7:0]                   r_delay, n_delay;
    logic                         r_is_read, n_is_read;
    logic [7:0]                   r_ctrl, n_ctrl;
    logic [7:0]                   r_value, n_value;
    logic                         r_ack_err, n_ack_err;
    logic [7:0]                   r_last, n_last;

    i2cm_pkg::t_entry             cur_e, new_e, out_e;
    logic [7:0]                   hold;
    logic [7:0]                   dly;
    logic [i2cm_pkg::BIT_W:0]     bit_sum;
    logic [7:0]                   shifted;
    logic [7:0]                   addr_byte;
    logic                         enter;
    logic                         done;

    assign hold      = (i_cfg.hold_ticks == 8'd0) ? 8'd1 : i_cfg.hold_ticks;
    assign addr_byte = {i_cfg.dev_addr, 1'b0};
    assign cur_e     = i2cm_pkg::prog_entry(r_is_read, r_phase);
    assign dly       = r_delay + 8'd1;
    assign bit_sum   = {1'b0, r_bit} + 5'd1;
    assign shifted   = {r_shift[6:0], i_sda};

    // Next state for one tick
    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_delay   = r_delay;
        n_is_read = r_is_read;
        n_ctrl    = r_ctrl;
        n_value   = r_value;
        n_ack_err = r_ack_err;
        n_last    = r_last;
        enter     = 1'b0;
        done      = 1'b0;
        if (i_step) begin
            if (r_phase == '0) begin
                if (i_op == i2cm_pkg::OP_READ || i_op == i2cm_pkg::OP_WRITE) begin
                    n_is_read = (i_op == i2cm_pkg::OP_READ);
                    n_ctrl    = i_ctrl;
                    n_value   = i_value;
                    n_ack_err = 1'b0;
                    n_phase   = 6'd1;
                    enter     = 1'b1;
                end
            end else begin
                n_delay = dly;
                if (dly >= hold) begin
                    n_delay = 8'd0;
                    // High half ends: shift out, shift in or sample the ack
                    if (r_bit[0]) begin
                        case (cur_e.kind)
                            i2cm_pkg::K_SEND: n_shift = {r_shift[6:0], 1'b0};
                            i2cm_pkg::K_RECV: begin
                                n_shift = shifted;
                                if (r_bit == 4'd15) begin
                                    n_last = shifted;
                                end
                            end
                            i2cm_pkg::K_ACK:  n_ack_err = r_ack_err | i_sda;
                            default: ;
                        endcase
                    end
                    n_bit = bit_sum[i2cm_pkg::BIT_W-1:0];
                    if (bit_sum >= i2cm_pkg::unit_length(cur_e.kind)) begin
                        n_phase = r_phase + 6'd1;
                        enter   = 1'b1;
                    end
                end
            end
        end

        // Step entry: restart counters and load the byte to send
        new_e = i2cm_pkg::prog_entry(n_is_read, n_phase);
        if (enter) begin
            n_bit   = '0;
            n_delay = 8'd0;
            case (new_e.kind)
                i2cm_pkg::K_END: begin
                    n_phase = '0;
                    done    = 1'b1;
                end
                i2cm_pkg::K_SEND: begin
                    case (new_e.arg)
                        i2cm_pkg::SRC_ADDR_WR: n_shift = addr_byte;
                        i2cm_pkg::SRC_ADDR_RD: n_shift = addr_byte | 8'd1;
                        i2cm_pkg::SRC_CTRL:    n_shift = n_ctrl;
                        i2cm_pkg::SRC_DAC_CMD: n_shift = i2cm_pkg::DAC_CMD_BYTE;
                        default:               n_shift = n_value;
                    endcase
                end
                i2cm_pkg::K_RECV: n_shift = 8'd0;
                default: ;
            endcase
        end
    end

    // Line levels and flags after this tick
    always_comb begin
        out_e           = i2cm_pkg::prog_entry(n_is_read, n_phase);
        o_res.scl_level = 1'b1;
        o_res.sda_level = 1'b1;
        if (n_phase != '0) begin
            if (out_e.kind == i2cm_pkg::K_FIX) begin
                o_res.scl_level = out_e.arg[1];
                o_res.sda_level = out_e.arg[0];
            end else begin
                o_res.scl_level = n_bit[0];
                o_res.sda_level = (out_e.kind == i2cm_pkg::K_SEND) ? n_shift[7] : 1'b1;
            end
        end
        o_res.busy_res  = (n_phase != '0);
        o_res.done_res  = done;
        o_res.read_data = n_last;
        o_res.nack_seen = n_ack_err;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_bit     <= '0;
            r_shift   <= 8'd0;
            r_delay   <= 8'd0;
            r_is_read <= 1'b0;
            r_ctrl    <= 8'd0;
            r_value   <= 8'd0;
            r_ack_err <= 1'b0;
            r_last    <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_delay   <= n_delay;
            r_is_read <= n_is_read;
            r_ctrl    <= n_ctrl;
            r_value   <= n_value;
            r_ack_err <= n_ack_err;
            r_last    <= n_last;
        end
    end

endmodule

// ===== rtl/core/i2c_adc_dac_transaction_master.sv =====
`timescale 1ns / 1ps
// A request's result is registered into the output register on the edge that takes it.
// Throughput: one request per cycle while o_s_tready is high; state updates once per tick.
// The output register lets a new request in while the held result is taken the same cycle.
// Reset (synchronous, active low): bus idle, counters and flags cleared, read data zero,
// half period 6 ticks and device address 72.

module i2c_adc_dac_transaction_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // control_byte[7:0], dac_value[15:8], sda_in[16], zero pad
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // scl_level[0], sda_level[1], busy_res[2],
                                     // read_data[10:3], nack_seen[11], zero pad
    output logic        o_m_tlast    // done_res
);

    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_DEV_ADDR    = 1'b1;

    i2cm_pkg::t_cfg    r_cfg;
    i2cm_pkg::t_result step_res;
    i2cm_pkg::t_result r_res;
    logic              r_m_valid;
    logic              accept;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks <= 8'd6;
            r_cfg.dev_addr   <= 7'd72;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_HALF_PERIOD: r_cfg.hold_ticks <= i_cfg_data;
                CFG_DEV_ADDR:    r_cfg.dev_addr   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_cfg   (r_cfg),
        .i_op    (i_s_tuser),
        .i_ctrl  (i_s_tdata[7:0]),
        .i_value (i_s_tdata[15:8]),
        .i_sda   (i_s_tdata[16]),
        .o_res   (step_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= step_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'd0, r_res.nack_seen, r_res.read_data, r_res.busy_res,
                         r_res.sda_level, r_res.scl_level};
    assign o_m_tlast  = r_res.done_res;

endmodule

// ===== rtl/core/i2cm_checker.sv =====
`timescale 1ns / 1ps

module i2cm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast
);

    // An empty output register never blocks a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("request blocked with empty output register");

    // A stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // The finishing tick is no longer busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> !o_m_tdata[2])
        else $error("done shown while busy");

    // An idle bus has both lines released
    a_idle_lines_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[2] |-> o_m_tdata[0] && o_m_tdata[1])
        else $error("bus lines driven while idle");

endmodule

bind i2c_adc_dac_transaction_master i2cm_checker u_i2cm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
